>>> rtl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants for the nearest neighbor search block.
// ----------------------------------------------------------------------------
package nns_pkg;

    // Fixed field widths
    localparam int NUM_DIMS   = 5;
    localparam int IDX_W      = 16;   // row index width in the tag and result types
    localparam int OUT_IDX_W  = 10;
    localparam int RIU_W      = 11;
    localparam int DIST_W     = 35;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b1;

    // Tag that travels with each row through the lanes
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             last;
    } tag_t;

    // Best match so far
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
        logic              early;
    } result_t;

endpackage

>>> rtl/nns_lane.sv
// ----------------------------------------------------------------------------
// nns_lane
// One coordinate lane: squared difference of query and row coordinate.
// ----------------------------------------------------------------------------
module nns_lane
    import nns_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic signed [COORD_BITS-1:0]  q,
    input  logic signed [COORD_BITS-1:0]  r,
    output logic [2*(COORD_BITS+1)-1:0]   sq
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [SQ_W-1:0]         sq_reg;

    // Take the magnitude of the difference
    assign diff = MAG_W'(q) - MAG_W'(r);
    assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // Register the square
    always_ff @(posedge clk)
    begin
        sq_reg <= SQ_W'(mag) * SQ_W'(mag);
    end

    assign sq = sq_reg;

endmodule

>>> rtl/nns_merge.sv
// ----------------------------------------------------------------------------
// nns_merge
// Sums the lane squares, saturates, and tracks the first strict minimum
// with early exit on the threshold.
// ----------------------------------------------------------------------------
module nns_merge
    import nns_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           row_vld,
    input  tag_t                           row_tag,
    input  logic [2*(COORD_BITS+1)-1:0]    sq [NUM_DIMS],
    input  logic [DIST_W-1:0]              threshold,
    output logic                           done,
    output result_t                        result
);

    localparam int SQ_W  = 2 * (COORD_BITS + 1);
    localparam int SUM_W = SQ_W + $clog2(NUM_DIMS);
    localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    logic              a_vld_reg, a_vld_next;
    tag_t              a_tag_reg;
    logic              b_vld_reg, b_vld_next;
    tag_t              b_tag_reg;
    logic [DIST_W-1:0] b_dist_reg, b_dist_next;
    logic [SUM_W-1:0]  sum;
    result_t           best_reg, best_next;
    logic              upd;
    logic              hit;

    // Add the lane squares and saturate
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            sum = sum + SUM_W'(sq[i]);
        end
        if (CMP_W'(sum) > CMP_W'(DIST_MAX))
            b_dist_next = DIST_MAX;
        else
            b_dist_next = DIST_W'(sum);
    end

    // Compare against the best and the early-exit threshold
    always_comb
    begin
        upd  = b_vld_reg && (b_tag_reg.first || (b_dist_reg < best_reg.distance));
        hit  = b_vld_reg && !b_tag_reg.first && (b_dist_reg < threshold);
        done = b_vld_reg && (hit || b_tag_reg.last);
        best_next = best_reg;
        if (upd)
        begin
            best_next.idx      = b_tag_reg.idx;
            best_next.distance = b_dist_reg;
        end
        if (b_vld_reg)
            best_next.early = hit;
    end

    // Drop rows still in flight once the scan is finished
    assign a_vld_next = row_vld && !done;
    assign b_vld_next = a_vld_reg && !done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tag_reg  <= row_tag;
        b_tag_reg  <= a_tag_reg;
        b_dist_reg <= b_dist_next;
        best_reg   <= best_next;
    end

    assign result = best_next;

endmodule

>>> rtl/nearest_neighbor_search.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_search
// Squared Euclidean nearest neighbor search over a table of stored rows.
// ----------------------------------------------------------------------------
// A load request (opcode 0) writes one reference row and gives no result.
// A query request (opcode 1) scans rows 0 to rows_in_use-1, the count
// clamped to 1..ROWS, at one row per cycle, the rate of the table's single
// read port, with one lane per coordinate and a merge stage behind them. The
// result is registered once the last row or an early-exit hit leaves the
// merge stage; the next request is taken once it is in the output register.
// Requests are stalled while a query runs. A finished result waits in the
// output register while the next request is taken. Rows must be loaded
// before a query reaches them; the table needs no clearing after reset.
module nearest_neighbor_search
    import nns_pkg::*;
#(
    parameter int ROWS       = 1024,
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          opcode,
    input  logic [9:0]                    row_index,
    input  logic signed [COORD_BITS-1:0]  coord_0,
    input  logic signed [COORD_BITS-1:0]  coord_1,
    input  logic signed [COORD_BITS-1:0]  coord_2,
    input  logic signed [COORD_BITS-1:0]  coord_3,
    input  logic signed [COORD_BITS-1:0]  coord_4,
    // result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [OUT_IDX_W-1:0]          nearest_index,
    output logic [DIST_W-1:0]             nearest_distance,
    output logic                          stopped_early,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [DIST_W-1:0]             cfg_data
);

    localparam int ROW_AW = $clog2(ROWS);
    localparam int SQ_W   = 2 * (COORD_BITS + 1);
    localparam int ROW_W  = NUM_DIMS * COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [RIU_W-1:0]         rows_in_use_reg;
    logic [DIST_W-1:0]        threshold_reg;
    logic [ROW_AW-1:0]        rd_addr_reg, rd_addr_next;
    logic [ROW_AW-1:0]        last_reg, last_next;
    logic                     issue_reg, issue_next;
    logic                     rd_vld_reg, rd_vld_next;
    tag_t                     rd_tag_reg;
    logic [ROW_W-1:0]         rdata_reg;
    logic [ROW_W-1:0]         mem [ROWS];
    logic signed [COORD_BITS-1:0] req_vec [NUM_DIMS];
    logic signed [COORD_BITS-1:0] qvec_reg [NUM_DIMS];
    logic signed [COORD_BITS-1:0] row_vec [NUM_DIMS];
    logic [SQ_W-1:0]          sq [NUM_DIMS];
    logic                     req_acc;
    logic                     load_acc;
    logic                     query_acc;
    logic                     rd_en;
    logic                     done;
    result_t                  result;
    logic                     out_free;
    logic                     out_load;
    logic [31:0]              row_index_ext;
    logic [31:0]              riu_ext;
    logic [31:0]              n_m1;
    logic                     res_valid_reg, res_valid_next;
    logic [OUT_IDX_W-1:0]     nearest_index_reg;
    logic [DIST_W-1:0]        nearest_distance_reg;
    logic                     stopped_early_reg;
    logic [IDX_W-1:0]         out_idx_ext;

    // Request handshake
    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign load_acc  = req_acc && (opcode == OP_LOAD);
    assign query_acc = req_acc && (opcode == OP_QUERY);

    assign req_vec[0] = coord_0;
    assign req_vec[1] = coord_1;
    assign req_vec[2] = coord_2;
    assign req_vec[3] = coord_3;
    assign req_vec[4] = coord_4;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= RIU_W'(1);
            threshold_reg   <= DIST_W'(66);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[RIU_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp the row count to 1..ROWS and keep the last index
    always_comb
    begin
        riu_ext = 32'(rows_in_use_reg);
        if (riu_ext == 32'd0)
            n_m1 = 32'd0;
        else if (riu_ext > 32'(ROWS))
            n_m1 = 32'(ROWS - 1);
        else
            n_m1 = riu_ext - 32'd1;
    end

    // Row table: one write port, one registered read port
    assign row_index_ext = 32'(row_index);

    always_ff @(posedge clk)
    begin
        if (load_acc && (row_index_ext < 32'(ROWS)))
        begin
            mem[row_index_ext[ROW_AW-1:0]] <= {coord_4, coord_3, coord_2, coord_1, coord_0};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // Latch the query vector and last row index, and tag each row read
    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                qvec_reg[i] <= req_vec[i];
            end
            last_reg <= last_next;
        end
        if (rd_en)
        begin
            rd_tag_reg.idx   <= IDX_W'(rd_addr_reg);
            rd_tag_reg.first <= (rd_addr_reg == '0);
            rd_tag_reg.last  <= (rd_addr_reg == last_reg);
        end
    end

    assign last_next = n_m1[ROW_AW-1:0];

    // Output register is free when empty or taken this cycle
    assign out_free = !res_valid_reg || !res_stall;
    assign rd_en    = (state_reg == ST_SCAN) && issue_reg && !done;

    // Scan sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_addr_next = rd_addr_reg;
        issue_next   = issue_reg;
        rd_vld_next  = rd_en;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next   = ST_SCAN;
                    rd_addr_next = '0;
                    issue_next   = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    issue_next = 1'b0;
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else if (rd_en)
                begin
                    if (rd_addr_reg == last_reg)
                        issue_next = 1'b0;
                    else
                        rd_addr_next = rd_addr_reg + ROW_AW'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_addr_reg <= '0;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    // Split the row into lane coordinates
    always_comb
    begin
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            row_vec[i] = rdata_reg[i*COORD_BITS +: COORD_BITS];
        end
    end

    // Coordinate lanes
    for (genvar g = 0; g < NUM_DIMS; g++)
    begin : g_lane
        nns_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk (clk),
            .q   (qvec_reg[g]),
            .r   (row_vec[g]),
            .sq  (sq[g])
        );
    end

    // Merge stage
    nns_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_vld   (rd_vld_reg),
        .row_tag   (rd_tag_reg),
        .sq        (sq),
        .threshold (threshold_reg),
        .done      (done),
        .result    (result)
    );

    // Result register
    assign out_idx_ext = result.idx;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            nearest_index_reg    <= out_idx_ext[OUT_IDX_W-1:0];
            nearest_distance_reg <= result.distance;
            stopped_early_reg    <= result.early;
        end
    end

    assign res_valid        = res_valid_reg;
    assign nearest_index    = nearest_index_reg;
    assign nearest_distance = nearest_distance_reg;
    assign stopped_early    = stopped_early_reg;

    // Checks on the scan control
    a_idle_no_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !issue_reg))
        else $error("row in flight while idle");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside a scan");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> res_valid_reg)
        else $error("result held with an empty output register");

    a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (rd_addr_reg <= last_reg))
        else $error("read address past the last row");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> ((state_reg == ST_SCAN) && issue_reg && (rd_addr_reg == '0)))
        else $error("query did not start a scan at row zero");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest neighbor search block.
// ----------------------------------------------------------------------------
// Loads reference rows and fires queries under random request gaps and
// result stalls. A scoreboard keeps its own copy of the row table and the
// two registers. For each query it works out the nearest row, its squared
// distance and the early-exit flag, and compares them with what comes back.
// Directed corner cases run first. Random phases follow, each with fresh
// register values, and a last phase sets row counts past the table size.
// ----------------------------------------------------------------------------
module tb_top;
    import nns_pkg::*;

    localparam int TABLE_ROWS   = 1024;
    localparam int COORD_W      = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_ITEMS  = 48;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 2000000;

    // One row or query vector; coord_0 sits in element 0
    typedef bit [NUM_DIMS-1:0][COORD_W-1:0] vec_t;

    typedef struct packed
    {
        bit [OUT_IDX_W-1:0] idx;
        bit [DIST_W-1:0]    distance;
        bit                 early;
    } answer_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the row table and registers, predicts each answer
    // ------------------------------------------------------------------------
    class nn_scoreboard;
        vec_t            ref_rows[TABLE_ROWS];
        bit [RIU_W-1:0]  rows_in_use;
        bit [DIST_W-1:0] exit_threshold;
        answer_t         pending[$];
        int              fail_count;

        function new();
            rows_in_use    = 11'd1;
            exit_threshold = 35'd66;
            fail_count     = 0;
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] index, bit [DIST_W-1:0] data);
            if (index == CFG_ROWS_IN_USE)
                rows_in_use = data[RIU_W-1:0];
            else
                exit_threshold = data;
        endfunction

        // Zero searches one row, anything past the table searches all of it
        function int unsigned rows_searched(bit [RIU_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > TABLE_ROWS)
                return TABLE_ROWS;
            return 32'(raw);
        endfunction

        function bit [DIST_W-1:0] squared_distance(vec_t a, vec_t b);
            longint sum;
            longint diff;
            int     i;
            sum = 0;
            for (i = 0; i < NUM_DIMS; i++)
            begin
                diff = longint'($signed(a[i])) - longint'($signed(b[i]));
                sum  = sum + diff * diff;
            end
            // Saturate; unreachable at 16-bit coordinates
            if (sum > longint'(DIST_MAX))
                return DIST_MAX;
            return sum[DIST_W-1:0];
        endfunction

        function void note_request(bit op, bit [9:0] index, vec_t vec);
            answer_t         ans;
            int unsigned     n;
            int unsigned     j;
            bit [DIST_W-1:0] d;
            if (op == OP_LOAD)
            begin
                ref_rows[index] = vec;
                return;
            end
            n            = rows_searched(rows_in_use);
            ans.idx      = '0;
            ans.distance = squared_distance(vec, ref_rows[0]);
            ans.early    = 1'b0;
            // Keep the first strict minimum; the exit check comes after it
            for (j = 1; j < n; j++)
            begin
                d = squared_distance(vec, ref_rows[j]);
                if (d < ans.distance)
                begin
                    ans.distance = d;
                    ans.idx      = j[OUT_IDX_W-1:0];
                end
                if (d < exit_threshold)
                begin
                    ans.early = 1'b1;
                    break;
                end
            end
            pending.push_back(ans);
        endfunction

        function void check_answer(logic [OUT_IDX_W-1:0] idx, logic [DIST_W-1:0] distance,
                                   logic early);
            answer_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none pending: index %0d distance %0d early %0b",
                         $time, idx, distance, early);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (idx !== want.idx)
            begin
                $display("%0t: nearest_index expected %0d actual %0d", $time, want.idx, idx);
                fail_count++;
            end
            if (distance !== want.distance)
            begin
                $display("%0t: nearest_distance expected %0d actual %0d",
                         $time, want.distance, distance);
                fail_count++;
            end
            if (early !== want.early)
            begin
                $display("%0t: stopped_early expected %0b actual %0b",
                         $time, want.early, early);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      opcode    = OP_LOAD;
    logic [9:0]                row_index = '0;
    logic signed [COORD_W-1:0] coord_0   = '0;
    logic signed [COORD_W-1:0] coord_1   = '0;
    logic signed [COORD_W-1:0] coord_2   = '0;
    logic signed [COORD_W-1:0] coord_3   = '0;
    logic signed [COORD_W-1:0] coord_4   = '0;
    logic                      res_stall = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_ROWS_IN_USE;
    logic [DIST_W-1:0]         cfg_data  = '0;

    logic                      req_stall;
    logic                      res_valid;
    logic [OUT_IDX_W-1:0]      nearest_index;
    logic [DIST_W-1:0]         nearest_distance;
    logic                      stopped_early;
    logic                      cfg_ready;

    nn_scoreboard sb;
    bit           quiet       = 1'b0;
    int           stall_left  = 0;
    int           cycle_count = 0;

    nearest_neighbor_search uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .opcode           (opcode),
        .row_index        (row_index),
        .coord_0          (coord_0),
        .coord_1          (coord_1),
        .coord_2          (coord_2),
        .coord_3          (coord_3),
        .coord_4          (coord_4),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance),
        .stopped_early    (stopped_early),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Mostly short, now and then long
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [9:0] random_index();
        bit [31:0] word;
        word = $urandom;
        return word[9:0];
    endfunction

    function automatic vec_t random_vec();
        vec_t      v;
        bit [31:0] word;
        int        i;
        for (i = 0; i < NUM_DIMS; i++)
        begin
            word = $urandom;
            v[i] = word[COORD_W-1:0];
        end
        return v;
    endfunction

    // Each coordinate at a boundary of the signed range or near zero
    function automatic vec_t extreme_vec();
        vec_t v;
        int   i;
        for (i = 0; i < NUM_DIMS; i++)
        begin
            case ($urandom_range(0, 4))
                0:       v[i] = 16'h8000;
                1:       v[i] = 16'h7FFF;
                2:       v[i] = 16'h0000;
                3:       v[i] = 16'hFFFF;
                default: v[i] = 16'h0001;
            endcase
        end
        return v;
    endfunction

    // Offset each coordinate by up to +/-spread, wrapping at 16 bits
    function automatic vec_t near_vec(vec_t base, int spread);
        vec_t v;
        int   delta;
        int   i;
        for (i = 0; i < NUM_DIMS; i++)
        begin
            delta = $urandom_range(0, 2 * spread) - spread;
            v[i]  = base[i] + delta[COORD_W-1:0];
        end
        return v;
    endfunction

    // Rows cluster around each other so ties and early exits show up
    function automatic vec_t make_row(int unsigned span);
        vec_t source;
        source = sb.ref_rows[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2:    return random_vec();
            3, 4, 5:    return near_vec(source, 16);
            6, 7:       return source;
            default:    return extreme_vec();
        endcase
    endfunction

    function automatic vec_t make_query(int unsigned span);
        vec_t source;
        source = sb.ref_rows[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 9))
            0, 1:       return random_vec();
            2, 3, 4:    return near_vec(source, 4);
            5:          return near_vec(source, 64);
            6, 7:       return source;
            default:    return extreme_vec();
        endcase
    endfunction

    function automatic bit [DIST_W-1:0] pick_threshold();
        bit [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 35'd66;
            2:       return DIST_W'($urandom_range(1, 400));
            3:       return DIST_W'($urandom_range(0, 100000));
            4:       return wide[DIST_W-1:0];
            default: return DIST_MAX;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Present one request and hold it until taken; valid stays high on return
    task automatic send_request(bit op, bit [9:0] index, vec_t vec);
        req_valid <= 1'b1;
        opcode    <= op;
        row_index <= index;
        coord_0   <= vec[0];
        coord_1   <= vec[1];
        coord_2   <= vec[2];
        coord_3   <= vec[3];
        coord_4   <= vec[4];
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(op, index, vec);
    endtask

    // Optionally idle the request side between requests
    task automatic req_pause();
        int unsigned idle;
        idle = 0;
        if (!quiet && $urandom_range(0, 1) == 1)
            idle = gap_length();
        if (idle != 0)
        begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Drop valid, wait out every pending answer, then let the pipe settle
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; only called while idle
    task automatic set_config(bit [RIU_W-1:0] rows, bit [DIST_W-1:0] threshold);
        bit [63:0] filler;
        filler    = {$urandom, $urandom};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_data  <= {filler[DIST_W-1:RIU_W], rows};
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(CFG_ROWS_IN_USE, {filler[DIST_W-1:RIU_W], rows});
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= threshold;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(CFG_THRESHOLD, threshold);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check every accepted answer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 4) == 0)
                stall_left <= gap_length();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_answer(nearest_index, nearest_distance, stopped_early);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        vec_t           low_corner;
        vec_t           high_corner;
        vec_t           mixed;
        vec_t           probe_a;
        vec_t           probe_b;
        bit [RIU_W-1:0] rows_raw;
        int unsigned    span;
        int unsigned    j;
        int             random_sent;
        int             k;

        sb          = new();
        random_sent = 0;
        low_corner  = {NUM_DIMS{16'h8000}};
        high_corner = {NUM_DIMS{16'h7FFF}};
        mixed       = {16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF};
        probe_a     = {16'h0000, 16'h8000, 16'h7FFF, 16'hFEDC, 16'h0123};
        probe_b     = probe_a;
        probe_b[0]  = probe_a[0] + 16'd1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers search row 0 only; largest and zero distance
        send_request(OP_LOAD, 10'd0, low_corner);
        req_pause();
        send_request(OP_QUERY, 10'h3FF, high_corner);
        req_pause();
        send_request(OP_QUERY, 10'h000, low_corner);
        req_pause();
        send_request(OP_QUERY, 10'h155, mixed);

        // Tie between rows 1 and 2 keeps row 1; no early exit at threshold zero
        drain();
        set_config(11'd4, '0);
        send_request(OP_LOAD, 10'd1, probe_a);
        req_pause();
        send_request(OP_LOAD, 10'd2, probe_a);
        req_pause();
        send_request(OP_LOAD, 10'd3, high_corner);
        req_pause();
        send_request(OP_QUERY, 10'h2AA, probe_a);
        req_pause();
        send_request(OP_QUERY, 10'h000, high_corner);

        // Early exit without improvement returns row 0; with improvement row 1
        drain();
        set_config(11'd4, 35'd1000);
        send_request(OP_LOAD, 10'd0, probe_a);
        req_pause();
        send_request(OP_LOAD, 10'd1, probe_b);
        req_pause();
        send_request(OP_QUERY, 10'h000, probe_a);
        req_pause();
        send_request(OP_QUERY, 10'h3FF, probe_b);

        // Rows in use zero searches one row; top threshold exits at row 1
        drain();
        set_config(11'd0, DIST_MAX);
        send_request(OP_QUERY, 10'h000, probe_b);
        drain();
        set_config(11'd2, DIST_MAX);
        send_request(OP_QUERY, 10'h000, high_corner);

        // Random phases, fresh registers each time; first one uses zero rows
        for (k = 0; random_sent < RANDOM_ITEMS; k++)
        begin
            if (k == 0)
                rows_raw = '0;
            else if ($urandom_range(0, 9) < 6)
                rows_raw = RIU_W'($urandom_range(1, 8));
            else if ($urandom_range(0, 3) != 0)
                rows_raw = RIU_W'($urandom_range(9, 40));
            else
                rows_raw = RIU_W'($urandom_range(41, 96));
            drain();
            set_config(rows_raw, pick_threshold());
            quiet = ($urandom_range(0, 4) == 0);
            span  = sb.rows_searched(rows_raw);

            // Load every row the query will reach
            for (j = 0; j < span; j++)
            begin
                send_request(OP_LOAD, j[9:0], make_row(span));
                req_pause();
            end

            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_request(OP_LOAD, random_index(), make_row(span));
                    else
                        send_request(OP_LOAD, 10'($urandom_range(0, span - 1)),
                                     make_row(span));
                end
                else
                    send_request(OP_QUERY, random_index(), make_query(span));
                random_sent++;
                // Hold off once until every pending answer is back
                if (random_sent == RANDOM_ITEMS / 2)
                    drain();
                else
                    req_pause();
            end
        end

        // Row counts past the table size; the top threshold exits at row 1
        drain();
        quiet = 1'b0;
        set_config(11'd2, DIST_MAX);
        send_request(OP_LOAD, 10'd0, make_row(2));
        req_pause();
        send_request(OP_LOAD, 10'd1, make_row(2));
        req_pause();
        for (k = 0; k < 2; k++)
        begin
            drain();
            if (k == 0)
                set_config(11'd2047, DIST_MAX);
            else
                set_config(11'd1025, DIST_MAX);
            repeat (3)
            begin
                send_request(OP_QUERY, random_index(), make_query(2));
                req_pause();
            end
        end

        drain();
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
